// File: sv/snac_pkg.sv
// Shared types, sizes and codes of the negative address cache.
package snac_pkg;

    // Cache geometry: the set count is a power of two by construction
    localparam int SET_W    = 4;
    localparam int SETS     = 1 << SET_W;
    localparam int WAYS     = 7;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRIES  = SETS * WAYS;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int PC_W     = 64;
    localparam int HASH_SHR = 3;
    localparam int SETO_W   = 4;

    // Operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    // Configuration port
    localparam int          CFG_ADDR_W = 3;
    localparam int          CFG_DATA_W = 32;
    localparam logic        REG_ENABLE = 1'b0;  // word index of the enable register

    typedef struct packed {
        logic            operation;
        logic [PC_W-1:0] pc;
    } t_in_item;

    typedef struct packed {
        logic              attempt_allowed;
        logic              known_invalid;
        logic [SETO_W-1:0] set_index;
    } t_out_item;

    // Access request from the sequencer to the entry store
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [PC_W-1:0]  wr_data;
    } t_store_req;

endpackage

// File: sv/sharded_negative_address_cache.sv
// Top level: sequencer that walks the ways of one set through a shared comparator.
//
//  channel  | signals                             | handshake
//  ---------+-------------------------------------+------------------------------------
//  command  | i_item (operation, pc)              | taken when i_start && !o_busy
//  result   | o_result (attempt, known, set)      | o_done high one cycle, no stall
//  config   | psel penable pwrite paddr pwdata    | write when psel&penable&pwrite&pready
//
//  After the accepting edge the sequencer runs S_SCAN, whose scan cycles each read
//  one way of the set from the entry memory, the comparator checking the way read
//  in the cycle before, then S_LAST finishes the result and any write; o_done is
//  registered from S_LAST. o_busy is high through S_SCAN and S_LAST and drops in
//  the result cycle, whose closing edge may take the next item, so a new item is
//  not taken before the result of the last one. Reset clears all entries to zero through
//  valid bits at once, with no clearing pass. Results cannot be stalled.
module sharded_negative_address_cache
    import snac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_in_item              i_item,
    output logic                  o_busy,
    output logic                  o_done,
    output t_out_item             o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_LAST = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic              r_op, n_op;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic [SET_W-1:0]  r_set, n_set;
    logic [WAY_W-1:0]  r_way, n_way;
    logic              r_hit, n_hit;
    logic              r_out_vld, n_out_vld;
    t_out_item         r_result, n_result;
    logic [WAY_W-1:0]  r_next_slot [SETS];

    logic              enable;
    t_store_req        store_req;
    logic [PC_W-1:0]   rd_data;
    logic              match;
    logic              final_hit;
    logic [PC_W-1:0]   hash;
    logic [IDX_W-1:0]  set_base;
    logic [WAY_W-1:0]  slot;
    logic [WAY_W-1:0]  slot_nxt;
    logic              slot_we;

    snac_apb u_apb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_enable (enable)
    );

    snac_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    // Hash the incoming address to its set
    assign hash     = i_item.pc ^ (i_item.pc >> HASH_SHR);
    assign set_base = IDX_W'(IDX_W'(r_set) * IDX_W'(WAYS));

    // Shared comparator against the way read in the previous cycle
    assign match     = (rd_data == r_pc);
    assign final_hit = r_hit | match;

    // Pick the round-robin slot and its successor
    always_comb begin
        slot = r_next_slot[r_set];
        if (32'(slot) >= WAYS) begin
            slot = '0;
        end
        slot_nxt = (32'(slot) == WAYS - 1) ? '0 : WAY_W'(slot + 1'b1);
    end

    // Sequence one item through its set
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_pc      = r_pc;
        n_set     = r_set;
        n_way     = r_way;
        n_hit     = r_hit;
        n_out_vld = 1'b0;
        n_result  = r_result;
        slot_we   = 1'b0;
        store_req = '0;
        store_req.rd_addr = IDX_W'(set_base + IDX_W'(r_way));
        store_req.wr_addr = IDX_W'(set_base + IDX_W'(slot));
        store_req.wr_data = r_pc;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_item.operation;
                    n_pc    = i_item.pc;
                    n_set   = hash[SET_W-1:0];
                    n_way   = '0;
                    n_hit   = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                store_req.rd_en = 1'b1;
                if (r_way != '0) begin
                    n_hit = final_hit;
                end
                if (32'(r_way) == WAYS - 1) begin
                    n_state = S_LAST;
                end else begin
                    n_way = WAY_W'(r_way + 1'b1);
                end
            end
            S_LAST: begin
                n_out_vld                = 1'b1;
                n_result.known_invalid   = final_hit;
                n_result.attempt_allowed = (r_op == OP_LOOKUP) && enable && !final_hit;
                n_result.set_index       = SETO_W'(r_set);
                if (r_op == OP_RECORD) begin
                    store_req.wr_en = 1'b1;
                    slot_we         = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // Hold item payload
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pc     <= n_pc;
        r_set    <= n_set;
        r_way    <= n_way;
        r_hit    <= n_hit;
        r_result <= n_result;
    end

    // Advance the slot pointer of the recorded set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) begin
                r_next_slot[s] <= '0;
            end
        end else if (slot_we) begin
            r_next_slot[r_set] <= slot_nxt;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_out_vld;
    assign o_result = r_result;

    // The way counter stays within the set while scanning
    a_way_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (32'(r_way) < WAYS))
        else $error("way counter left the set");

    // The finishing cycle always produces exactly one result strobe
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST) |=> o_done)
        else $error("result strobe missing after finish");

    // A result strobe only follows a finishing cycle
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_LAST))
        else $error("result strobe without a finished item");

    // An allowed attempt never comes with a known match
    a_allow_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.attempt_allowed) |-> !o_result.known_invalid)
        else $error("attempt allowed for a listed address");

endmodule

// File: sv/snac_apb.sv
// Configuration register bank with an APB-style write and read port.
module snac_apb
    import snac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  o_enable
);

    logic r_enable;
    logic sel_enable;
    logic wr_fire;

    // Decode the word address; the byte lanes are ignored
    assign sel_enable = (paddr[2] == REG_ENABLE);
    assign wr_fire    = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    // Write the enable bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (wr_fire && sel_enable) begin
            r_enable <= pwdata[0];
        end
    end

    // Return the register value; unmapped words read as zero
    always_comb begin
        prdata = '0;
        if (sel_enable) begin
            prdata[0] = r_enable;
        end
    end

    assign o_enable = r_enable;

endmodule

// File: sv/snac_store.sv
// Entry store: one write and one registered read a cycle, with per-entry valid bits.
module snac_store
    import snac_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_req       i_req,
    output logic [PC_W-1:0]  o_rd_data
);

    logic [PC_W-1:0] mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [PC_W-1:0] r_rd_data;
    logic            r_rd_valid;

    // Write the memory array
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Read the memory array, registered
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    // Track written entries; an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench of the sharded negative address cache.
module tb_top;
    import snac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_CYCLES = WAYS + 2;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 4;
    localparam int PHASE_ITEMS = 270;
    localparam int POOL_DEPTH  = 48;
    localparam logic [CFG_ADDR_W-1:0] ENABLE_ADDR = CFG_ADDR_W'(4 * int'(REG_ENABLE));

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_in_item    item;
        logic        pinned;
        t_out_item   want;
        logic [31:0] wdata;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_start;
    t_in_item              i_item;
    logic                  o_busy;
    logic                  o_done;
    t_out_item             o_result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow copy of the cache contents and the enable register
    logic [PC_W-1:0]  tag_store [SETS][WAYS];
    logic [WAY_W-1:0] fill_ptr [SETS];
    logic             enable_q;

    t_out_item   pending_results[$];
    t_stim_row   stim_rows[$];
    logic [PC_W-1:0] recorded_pcs[$];
    logic [6:0]  hot_low [2];

    int unsigned errors;
    int unsigned n_results;
    int unsigned n_lookup;
    int unsigned n_record;
    int unsigned n_hit;
    int unsigned n_allowed;
    int unsigned n_cfg;
    int unsigned stall_cycles;

    sharded_negative_address_cache i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Look up or record one address in the shadow cache and return its answer
    function automatic t_out_item cache_access(input t_in_item it);
        logic [PC_W-1:0]  mix;
        logic [SET_W-1:0] s;
        logic [WAY_W-1:0] slot;
        logic             hit;
        t_out_item        r;
        mix = it.pc ^ (it.pc >> HASH_SHR);
        s   = mix[SET_W-1:0];
        hit = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (tag_store[s][w] == it.pc) hit = 1'b1;
        end
        r.attempt_allowed = (it.operation == OP_LOOKUP) && enable_q && !hit;
        r.known_invalid   = hit;
        r.set_index       = SETO_W'(s);
        // Overwrite the oldest way of the set, then advance and wrap the pointer
        if (it.operation == OP_RECORD) begin
            slot = fill_ptr[s];
            if (slot >= WAYS) slot = '0;
            tag_store[s][slot] = it.pc;
            fill_ptr[s] = (slot == WAY_W'(WAYS - 1)) ? '0 : slot + 1'b1;
        end
        return r;
    endfunction

    // Pick an address: reuse recorded ones, crowd two sets, use a small address, or go fully random
    function automatic logic [PC_W-1:0] pick_pc();
        logic [PC_W-1:0] pc;
        int unsigned     roll;
        roll = $urandom_range(99);
        pc   = {$urandom, $urandom};
        if (roll < 30 && recorded_pcs.size() != 0) begin
            pc = recorded_pcs[$urandom_range(recorded_pcs.size() - 1)];
        end else if (roll < 55) begin
            pc[6:0] = hot_low[$urandom_range(1)];
        end else if (roll < 65) begin
            pc = PC_W'($urandom_range(15));
        end
        return pc;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH result %0d %s: got %0h, expected %0h", n_results, what, got, want);
        errors++;
    endtask

    // Hold one item on the command port until taken, then log its expected result
    task automatic issue(input t_in_item it, input logic pinned, input t_out_item want);
        t_out_item pred;
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
        pred = cache_access(it);
        pending_results.push_back(pinned ? want : pred);
        if (it.operation == OP_LOOKUP) n_lookup++;
        else n_record++;
        if (pred.known_invalid) n_hit++;
        if (pred.attempt_allowed) n_allowed++;
    endtask

    // Drop start for a random stretch now and then
    task automatic idle_gap(input logic quiet);
        if (!quiet && $urandom_range(99) < 10) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Write the enable register once the cache has drained
    task automatic set_enable(input logic [31:0] data);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ENABLE_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        enable_q = data[0];
        n_cfg++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic add_item(input logic op, input logic [PC_W-1:0] pc);
        t_stim_row row;
        row.kind           = ROW_ITEM;
        row.item.operation = op;
        row.item.pc        = pc;
        row.pinned         = 1'b0;
        row.want           = '0;
        row.wdata          = '0;
        stim_rows.push_back(row);
    endtask

    task automatic add_pinned(input logic op, input logic [PC_W-1:0] pc, input logic allowed,
                              input logic known, input logic [SETO_W-1:0] set_idx);
        t_stim_row row;
        row.kind                 = ROW_ITEM;
        row.item.operation       = op;
        row.item.pc              = pc;
        row.pinned               = 1'b1;
        row.want.attempt_allowed = allowed;
        row.want.known_invalid   = known;
        row.want.set_index       = set_idx;
        row.wdata                = '0;
        stim_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [31:0] data);
        t_stim_row row;
        row.kind   = ROW_CFG;
        row.item   = '0;
        row.pinned = 1'b0;
        row.want   = '0;
        row.wdata  = data;
        stim_rows.push_back(row);
    endtask

    // Compare each result strobe with the oldest expectation; watch for a hang
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_result), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_result.attempt_allowed !== want.attempt_allowed)
                    report_mismatch("attempt_allowed", 64'(o_result.attempt_allowed),
                                    64'(want.attempt_allowed));
                if (o_result.known_invalid !== want.known_invalid)
                    report_mismatch("known_invalid", 64'(o_result.known_invalid),
                                    64'(want.known_invalid));
                if (o_result.set_index !== want.set_index)
                    report_mismatch("set_index", 64'(o_result.set_index),
                                    64'(want.set_index));
            end
            n_results++;
        end
        if ((i_start && !o_busy) || o_done || (psel && penable && pwrite && pready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : main
        t_in_item    it;
        logic [31:0] data;
        int          last;

        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        errors = 0; n_results = 0; n_lookup = 0; n_record = 0;
        n_hit = 0; n_allowed = 0; n_cfg = 0; stall_cycles = 0;
        enable_q = 1'b0;
        for (int s = 0; s < SETS; s++) begin
            fill_ptr[s] = '0;
            for (int w = 0; w < WAYS; w++) tag_store[s][w] = '0;
        end

        // Directed rows: cleared store matches address zero, disabled and enabled
        // lookups, record while disabled, re-record of a listed address, pointer wrap
        add_cfg(32'hFFFF_FFFE);
        add_pinned(OP_LOOKUP, 64'h0, 1'b0, 1'b1, 4'h0);
        add_pinned(OP_LOOKUP, '1, 1'b0, 1'b0, 4'h0);
        add_pinned(OP_RECORD, '1, 1'b0, 1'b0, 4'h0);
        add_pinned(OP_LOOKUP, '1, 1'b0, 1'b1, 4'h0);
        add_cfg(32'hFFFF_FFFF);
        add_pinned(OP_LOOKUP, 64'h1, 1'b1, 1'b0, 4'h1);
        add_pinned(OP_LOOKUP, 64'h0, 1'b0, 1'b1, 4'h0);
        add_pinned(OP_RECORD, '1, 1'b0, 1'b1, 4'h0);
        add_pinned(OP_LOOKUP, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 4'h0);
        // Fill set zero past its last way so the pointer wraps and evicts
        for (int k = 1; k <= 8; k++) add_item(OP_RECORD, PC_W'(k) << 8);
        add_item(OP_LOOKUP, 64'h100);
        add_item(OP_LOOKUP, 64'h0);
        add_item(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
        add_item(OP_RECORD, 64'h5555_5555_5555_5555);
        add_item(OP_LOOKUP, 64'h5555_5555_5555_5555);
        add_cfg(32'h0);
        add_item(OP_LOOKUP, 64'h800);

        // Hold reset, then release it
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed rows
        last = stim_rows.size() - 1;
        for (int r = 0; r <= last; r++) begin
            if (stim_rows[r].kind == ROW_CFG) begin
                set_enable(stim_rows[r].wdata);
            end else begin
                issue(stim_rows[r].item, stim_rows[r].pinned, stim_rows[r].want);
                if (r == last || stim_rows[r + 1].kind == ROW_CFG) i_start <= 1'b0;
                else idle_gap(1'b0);
            end
        end

        // Random phases, each under its own enable setting and pair of crowded sets
        for (int p = 0; p < PHASES; p++) begin
            data    = $urandom;
            data[0] = (p == 1) ? 1'b0 : (p == 3) ? 1'($urandom_range(1)) : 1'b1;
            set_enable(data);
            hot_low[0] = 7'($urandom_range(127));
            hot_low[1] = 7'($urandom_range(127));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                it.operation = ($urandom_range(99) < 35) ? OP_RECORD : OP_LOOKUP;
                it.pc        = pick_pc();
                issue(it, 1'b0, '0);
                if (it.operation == OP_RECORD) begin
                    recorded_pcs.push_back(it.pc);
                    if (recorded_pcs.size() > POOL_DEPTH) void'(recorded_pcs.pop_front());
                end
                if (i == PHASE_ITEMS - 1) i_start <= 1'b0;
                else idle_gap(p == 0 && i >= 40 && i < 240);
            end
        end

        // Drain the outstanding results
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (ITEM_CYCLES + 3) @(posedge i_clk);

        $display("Ran %0d lookups (%0d allowed) and %0d records, %0d hitting a listed address",
                 n_lookup, n_allowed, n_record, n_hit);
        $display("Checked %0d results across %0d enable register writes", n_results, n_cfg);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sharded_negative_address_cache.f
sv/snac_pkg.sv
sv/snac_apb.sv
sv/snac_store.sv
sv/sharded_negative_address_cache.sv
tb/tb_top.sv
